// ===== hw/rtl/i2ch_pkg.sv =====
// Package for the I2C host / MCU register model: access codes and
// MCU register map constants. No dependencies.
package i2ch_pkg;

    localparam int unsigned OPCODE_W = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WR_DATA = 3'd0,
        OP_WR_CTRL = 3'd1,
        OP_RD_DATA = 3'd2,
        OP_RD_CTRL = 3'd3,
        OP_EVENT   = 3'd4
    } opcode_t;

    // control byte bits
    localparam int unsigned CTRL_ENABLE = 7;
    localparam int unsigned CTRL_IRQ    = 6;
    localparam int unsigned CTRL_READ   = 5;
    localparam int unsigned CTRL_ACK    = 4;
    localparam int unsigned CTRL_START  = 1;

    localparam logic [1:0] MCU_BUS        = 2'd1;
    localparam logic [7:0] MCU_DEV_WRITE  = 8'h4A;
    localparam logic [7:0] MCU_DEV_READ   = 8'h4B;
    localparam logic [7:0] MCU_DEV_MASK   = 8'hFE;
    localparam logic [7:0] REG_PWR_FLAGS  = 8'h0F;
    localparam logic [7:0] PWR_FLAGS_VAL  = 8'h02;
    localparam logic [5:0] REG_IRQ_FLAGS  = 6'h04;  // 0x10..0x13, addr[7:2]
    localparam logic [5:0] REG_IRQ_MASK   = 6'h06;  // 0x18..0x1B, addr[7:2]
    localparam logic [7:0] REG_LCD_POWER  = 8'h22;

    // register addresses that turn auto-increment off
    localparam logic [7:0] NOINC_A = 8'h29;
    localparam logic [7:0] NOINC_B = 8'h2D;
    localparam logic [7:0] NOINC_C = 8'h4F;
    localparam logic [7:0] NOINC_D = 8'h61;
    localparam logic [7:0] NOINC_E = 8'h7F;

    localparam logic [1:0] WCOUNT_MAX = 2'd3;

endpackage

// ===== hw/rtl/i2c_host_with_mcu_register_model.sv =====
// Top level of the I2C host / power MCU register model.
// Depends on i2ch_pkg (access codes, register map constants).
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_ready  | opcode, bus_index, write_value, event_mask
//  out     | out_valid/out_ready| read_value, bus_irq_fired, mcu_irq_fired
//
// One access per cycle sustained while out_ready stays high; each access passes
// through the input register, then the result register. State updates as an
// access moves into the result register, so every access sees all earlier ones.
// rst_n clears all bus, address and MCU state to zero.
// A stalled result register holds the input register, which takes a new
// transfer as soon as it moves on.
module i2c_host_with_mcu_register_model #(
    parameter int unsigned NUM_BUSES = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [1:0]  bus_index,
    input  logic [7:0]  write_value,
    input  logic [31:0] event_mask,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_value,
    output logic        bus_irq_fired,
    output logic        mcu_irq_fired
);

    localparam int unsigned BUS_IDX_W = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;
    localparam logic [2:0]  NUM_BUSES_C = 3'(NUM_BUSES);

    // input register
    logic        s1_valid_reg;
    logic [2:0]  s1_opcode_reg;
    logic [1:0]  s1_bus_reg;
    logic [7:0]  s1_value_reg;
    logic [31:0] s1_event_reg;

    // result register
    logic        out_valid_reg;
    logic [7:0]  read_value_reg;
    logic        bus_irq_reg;
    logic        mcu_irq_reg;

    // block state
    logic [7:0]  data_reg [NUM_BUSES];
    logic [6:0]  ctrl_reg [NUM_BUSES];
    logic [1:0]  wcount_reg;
    logic [7:0]  dev_addr_reg;
    logic [7:0]  reg_addr_reg;
    logic        auto_inc_reg;
    logic [31:0] irq_flags_reg;
    logic [31:0] irq_mask_reg;

    logic [1:0]  wcount_next;
    logic [7:0]  dev_addr_next;
    logic [7:0]  reg_addr_next;
    logic        auto_inc_next;
    logic [31:0] irq_flags_next;
    logic [31:0] irq_mask_next;
    logic [7:0]  data_next;
    logic [6:0]  ctrl_next;
    logic        entry_we;
    logic [7:0]  read_value_next;
    logic        bus_irq_next;
    logic        mcu_irq_next;

    logic                 s1_adv;
    logic                 s1_fire;
    logic [BUS_IDX_W-1:0] idx;
    logic                 bus_ok;
    logic [7:0]           data_cur;
    logic [6:0]           ctrl_cur;

    assign s1_adv   = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_ready = !s1_valid_reg || s1_adv;

    assign idx      = s1_bus_reg[BUS_IDX_W-1:0];
    assign bus_ok   = {1'b0, s1_bus_reg} < NUM_BUSES_C;
    assign data_cur = data_reg[idx];
    assign ctrl_cur = ctrl_reg[idx];

    always_comb
    begin
        logic        is_mcu_bus;
        logic [1:0]  wc0;
        logic [1:0]  wc1;
        logic [4:0]  byte_sh;
        logic        rd_hit;
        logic [7:0]  rd_byte;
        logic [31:0] rd_flags;
        logic [31:0] mask_w;
        logic [31:0] lcd_bits;
        logic [31:0] flags_ev;

        wcount_next     = wcount_reg;
        dev_addr_next   = dev_addr_reg;
        reg_addr_next   = reg_addr_reg;
        auto_inc_next   = auto_inc_reg;
        irq_flags_next  = irq_flags_reg;
        irq_mask_next   = irq_mask_reg;
        data_next       = data_cur;
        ctrl_next       = ctrl_cur;
        entry_we        = 1'b0;
        read_value_next = 8'd0;
        bus_irq_next    = 1'b0;
        mcu_irq_next    = 1'b0;

        is_mcu_bus = (s1_bus_reg == i2ch_pkg::MCU_BUS);
        byte_sh    = {reg_addr_reg[1:0], 3'b000};

        // MCU read decode
        rd_hit   = 1'b0;
        rd_byte  = 8'd0;
        rd_flags = irq_flags_reg;
        if (is_mcu_bus && dev_addr_reg == i2ch_pkg::MCU_DEV_READ)
        begin
            if (reg_addr_reg == i2ch_pkg::REG_PWR_FLAGS)
            begin
                rd_hit  = 1'b1;
                rd_byte = i2ch_pkg::PWR_FLAGS_VAL;
            end
            else if (reg_addr_reg[7:2] == i2ch_pkg::REG_IRQ_FLAGS)
            begin
                rd_hit   = 1'b1;
                rd_byte  = irq_flags_reg[byte_sh +: 8];
                rd_flags = irq_flags_reg & ~(32'hFF << byte_sh);
            end
            else if (reg_addr_reg[7:2] == i2ch_pkg::REG_IRQ_MASK)
            begin
                rd_hit  = 1'b1;
                rd_byte = irq_mask_reg[byte_sh +: 8];
            end
        end

        // MCU write operands (value written is the bus data register)
        mask_w = irq_mask_reg;
        mask_w[byte_sh +: 8] = data_cur;
        lcd_bits = {2'b00, data_cur[5], data_cur[4] | data_cur[0], data_cur[3],
                    data_cur[2] | data_cur[0], data_cur[1], data_cur[0], 24'd0};
        flags_ev = irq_flags_reg | s1_event_reg;

        wc0 = s1_value_reg[i2ch_pkg::CTRL_START] ? 2'd0 : wcount_reg;
        wc1 = (wc0 == i2ch_pkg::WCOUNT_MAX) ? wc0 : wc0 + 2'd1;

        case (s1_opcode_reg)
            i2ch_pkg::OP_EVENT:
            begin
                irq_flags_next = flags_ev;
                mcu_irq_next   = (flags_ev & ~irq_mask_reg) != 32'd0;
            end
            i2ch_pkg::OP_WR_DATA:
            begin
                if (bus_ok)
                begin
                    entry_we  = 1'b1;
                    data_next = s1_value_reg;
                end
            end
            i2ch_pkg::OP_RD_DATA:
            begin
                if (bus_ok)
                    read_value_next = data_cur;
            end
            i2ch_pkg::OP_RD_CTRL:
            begin
                if (bus_ok)
                    read_value_next = {1'b0, ctrl_cur};
            end
            i2ch_pkg::OP_WR_CTRL:
            begin
                if (bus_ok)
                begin
                    entry_we  = 1'b1;
                    ctrl_next = s1_value_reg[6:0];
                    if (s1_value_reg[i2ch_pkg::CTRL_ENABLE])
                    begin
                        bus_irq_next = s1_value_reg[i2ch_pkg::CTRL_IRQ];
                        wcount_next  = wc0;
                        if (s1_value_reg[i2ch_pkg::CTRL_READ])
                        begin
                            data_next      = rd_byte;
                            irq_flags_next = rd_flags;
                            if (rd_hit)
                                reg_addr_next = reg_addr_reg + {7'd0, auto_inc_reg};
                        end
                        else
                        begin
                            ctrl_next[i2ch_pkg::CTRL_ACK] = 1'b1;
                            wcount_next = wc1;
                            if (wc1 == 2'd1)
                                dev_addr_next = data_cur;
                            else if (wc1 == 2'd2)
                            begin
                                reg_addr_next = data_cur;
                                if (is_mcu_bus && (dev_addr_reg & i2ch_pkg::MCU_DEV_MASK)
                                        == i2ch_pkg::MCU_DEV_WRITE)
                                    auto_inc_next = data_cur != i2ch_pkg::NOINC_A &&
                                                    data_cur != i2ch_pkg::NOINC_B &&
                                                    data_cur != i2ch_pkg::NOINC_C &&
                                                    data_cur != i2ch_pkg::NOINC_D &&
                                                    data_cur != i2ch_pkg::NOINC_E;
                            end
                            else if (is_mcu_bus && dev_addr_reg == i2ch_pkg::MCU_DEV_WRITE)
                            begin
                                if (reg_addr_reg[7:2] == i2ch_pkg::REG_IRQ_MASK)
                                begin
                                    irq_mask_next = mask_w;
                                    mcu_irq_next  = (irq_flags_reg & ~mask_w) != 32'd0;
                                    reg_addr_next = reg_addr_reg + {7'd0, auto_inc_reg};
                                end
                                else if (reg_addr_reg == i2ch_pkg::REG_LCD_POWER)
                                begin
                                    irq_flags_next = irq_flags_reg | lcd_bits;
                                    // merged raise: fires if any command bit was set and a flag is unmasked
                                    mcu_irq_next = (data_cur[5:0] != 6'd0) &&
                                        (((irq_flags_reg | lcd_bits) & ~irq_mask_reg)
                                         != 32'd0);
                                    reg_addr_next = reg_addr_reg + {7'd0, auto_inc_reg};
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
                entry_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wcount_reg    <= 2'd0;
            dev_addr_reg  <= 8'd0;
            reg_addr_reg  <= 8'd0;
            auto_inc_reg  <= 1'b0;
            irq_flags_reg <= 32'd0;
            irq_mask_reg  <= 32'd0;
            for (int k = 0; k < NUM_BUSES; k++)
            begin
                data_reg[k] <= 8'd0;
                ctrl_reg[k] <= 7'd0;
            end
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
            if (s1_fire)
            begin
                wcount_reg    <= wcount_next;
                dev_addr_reg  <= dev_addr_next;
                reg_addr_reg  <= reg_addr_next;
                auto_inc_reg  <= auto_inc_next;
                irq_flags_reg <= irq_flags_next;
                irq_mask_reg  <= irq_mask_next;
                for (int k = 0; k < NUM_BUSES; k++)
                begin
                    if (entry_we && idx == BUS_IDX_W'(k))
                    begin
                        data_reg[k] <= data_next;
                        ctrl_reg[k] <= ctrl_next;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_opcode_reg <= opcode;
            s1_bus_reg    <= bus_index;
            s1_value_reg  <= write_value;
            s1_event_reg  <= event_mask;
        end
        if (s1_fire)
        begin
            read_value_reg <= read_value_next;
            bus_irq_reg    <= bus_irq_next;
            mcu_irq_reg    <= mcu_irq_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_value    = read_value_reg;
    assign bus_irq_fired = bus_irq_reg;
    assign mcu_irq_fired = mcu_irq_reg;

`ifndef SYNTHESIS
    a_fire_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("accepted access did not reach result register");

    a_blocked_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("input register dropped a stalled access");

    a_irq_only_on_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && read_value_reg != 8'd0) |-> (!bus_irq_reg && !mcu_irq_reg))
        else $error("interrupt pulse on a read access");

    a_mcu_irq_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && mcu_irq_next) |=> ((irq_flags_reg & ~irq_mask_reg) != 32'd0))
        else $error("MCU interrupt fired with no unmasked flag");
`endif

endmodule

// ===== tb/i2ch_result_checker.sv =====
// Result checker for the I2C host / power MCU register model.
// Watches both channels, predicts each result, compares in order.
// Depends on i2ch_pkg (access codes, control bits, MCU map constants).
module i2ch_result_checker #(
    parameter int unsigned NUM_BUSES = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [1:0]  bus_index,
    input  logic [7:0]  write_value,
    input  logic [31:0] event_mask,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  read_value,
    input  logic        bus_irq_fired,
    input  logic        mcu_irq_fired,
    output int          mismatch_count,
    output int          expected_left
);

    // LCD power command bit 0 sets flags 24, 26 and 28 together
    localparam logic [31:0] LCD_MAIN_FLAGS = 32'h1500_0000;
    localparam int unsigned LCD_FLAG_BASE  = 24;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef struct packed {
        logic [7:0] read_value;
        logic       bus_irq;
        logic       mcu_irq;
    } access_result_t;

    logic [7:0]  data_regs [NUM_BUSES];
    logic [6:0]  ctrl_regs [NUM_BUSES];
    logic [1:0]  write_count;
    logic [7:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic        auto_inc;
    logic [31:0] mcu_flags;
    logic [31:0] mcu_mask;

    access_result_t expected_results[$];

    function automatic logic raise_flags(logic [31:0] bits);
        mcu_flags = mcu_flags | bits;
        return (mcu_flags & ~mcu_mask) != 32'd0;
    endfunction

    // read transfer from the addressed MCU register; unmapped gives 0
    function automatic logic [7:0] mcu_read(logic [1:0] bus);
        logic [7:0] r;
        logic       hit;
        int         sh;
        r   = 8'd0;
        hit = 1'b0;
        sh  = 8 * reg_addr[1:0];
        if (bus == i2ch_pkg::MCU_BUS && dev_addr == i2ch_pkg::MCU_DEV_READ)
        begin
            if (reg_addr == i2ch_pkg::REG_PWR_FLAGS)
            begin
                r   = i2ch_pkg::PWR_FLAGS_VAL;
                hit = 1'b1;
            end
            else if (reg_addr[7:2] == i2ch_pkg::REG_IRQ_FLAGS)
            begin
                r         = mcu_flags[sh +: 8];
                mcu_flags = mcu_flags & ~(32'hFF << sh);
                hit       = 1'b1;
            end
            else if (reg_addr[7:2] == i2ch_pkg::REG_IRQ_MASK)
            begin
                r   = mcu_mask[sh +: 8];
                hit = 1'b1;
            end
        end
        if (hit)
            reg_addr = reg_addr + 8'(auto_inc);
        return r;
    endfunction

    function automatic logic mcu_write(logic [1:0] bus, logic [7:0] v);
        logic fired;
        int   sh;
        fired = 1'b0;
        sh    = 8 * reg_addr[1:0];
        if (bus == i2ch_pkg::MCU_BUS && dev_addr == i2ch_pkg::MCU_DEV_WRITE)
        begin
            if (reg_addr[7:2] == i2ch_pkg::REG_IRQ_MASK)
            begin
                mcu_mask[sh +: 8] = v;
                fired    = raise_flags(32'd0);
                reg_addr = reg_addr + 8'(auto_inc);
            end
            else if (reg_addr == i2ch_pkg::REG_LCD_POWER)
            begin
                if (v[0])
                    fired = raise_flags(LCD_MAIN_FLAGS) | fired;
                for (int i = 1; i <= 5; i++)
                    if (v[i])
                        fired = raise_flags(32'd1 << (LCD_FLAG_BASE + i)) | fired;
                reg_addr = reg_addr + 8'(auto_inc);
            end
        end
        return fired;
    endfunction

    function automatic access_result_t apply_access(logic [2:0] op, logic [1:0] bus,
                                                   logic [7:0] v, logic [31:0] ev);
        access_result_t r;
        r = '0;
        if (op == i2ch_pkg::OP_EVENT)
        begin
            r.mcu_irq = raise_flags(ev);
        end
        else if (op <= i2ch_pkg::OP_RD_CTRL && bus < NUM_BUSES)
        begin
            case (op)
                i2ch_pkg::OP_WR_DATA: data_regs[bus] = v;
                i2ch_pkg::OP_RD_DATA: r.read_value = data_regs[bus];
                i2ch_pkg::OP_RD_CTRL: r.read_value = {1'b0, ctrl_regs[bus]};
                default:
                begin
                    ctrl_regs[bus] = v[6:0];
                    if (v[i2ch_pkg::CTRL_ENABLE])
                    begin
                        if (v[i2ch_pkg::CTRL_START])
                            write_count = 2'd0;
                        r.bus_irq = v[i2ch_pkg::CTRL_IRQ];
                        if (v[i2ch_pkg::CTRL_READ])
                        begin
                            data_regs[bus] = mcu_read(bus);
                        end
                        else
                        begin
                            ctrl_regs[bus][i2ch_pkg::CTRL_ACK] = 1'b1;
                            if (write_count != i2ch_pkg::WCOUNT_MAX)
                                write_count = write_count + 2'd1;
                            if (write_count == 2'd1)
                            begin
                                dev_addr = data_regs[bus];
                            end
                            else if (write_count == 2'd2)
                            begin
                                reg_addr = data_regs[bus];
                                if (bus == i2ch_pkg::MCU_BUS
                                    && (dev_addr & i2ch_pkg::MCU_DEV_MASK)
                                       == i2ch_pkg::MCU_DEV_WRITE)
                                    auto_inc = !(reg_addr == i2ch_pkg::NOINC_A
                                        || reg_addr == i2ch_pkg::NOINC_B
                                        || reg_addr == i2ch_pkg::NOINC_C
                                        || reg_addr == i2ch_pkg::NOINC_D
                                        || reg_addr == i2ch_pkg::NOINC_E);
                            end
                            else
                            begin
                                r.mcu_irq = mcu_write(bus, data_regs[bus]);
                            end
                        end
                    end
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        access_result_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUSES; i++)
            begin
                data_regs[i] = 8'd0;
                ctrl_regs[i] = 7'd0;
            end
            write_count = 2'd0;
            dev_addr    = 8'd0;
            reg_addr    = 8'd0;
            auto_inc    = 1'b0;
            mcu_flags   = 32'd0;
            mcu_mask    = 32'd0;
            expected_results.delete();
            mismatch_count = 0;
            expected_left  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("unexpected result: read_value %02h bus_irq %0b mcu_irq %0b",
                                 read_value, bus_irq_fired, mcu_irq_fired);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (read_value !== exp_r.read_value || bus_irq_fired !== exp_r.bus_irq
                        || mcu_irq_fired !== exp_r.mcu_irq)
                    begin
                        if (mismatch_count < MAX_REPORTS)
                            $display({"result mismatch (exp/act): read_value %02h/%02h",
                                      " bus_irq %0b/%0b mcu_irq %0b/%0b"},
                                     exp_r.read_value, read_value, exp_r.bus_irq,
                                     bus_irq_fired, exp_r.mcu_irq, mcu_irq_fired);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_access(opcode, bus_index, write_value,
                                                        event_mask));
            expected_left = expected_results.size();
        end
    end

endmodule

// ===== tb/tb_i2c_host_with_mcu_register_model.sv =====
// Testbench top for i2c_host_with_mcu_register_model: clock, reset, access
// stimulus (directed, then random MCU transfer sequences) and the verdict.
// Depends on i2ch_pkg, the block and i2ch_result_checker.
module tb_i2c_host_with_mcu_register_model;

    localparam int unsigned NUM_BUSES        = 3;
    localparam int          ITEM_TARGET      = 1250;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT      = 200000;
    localparam logic [2:0]  OP_RSVD_FIRST    = 3'd5;
    localparam logic [2:0]  OP_RSVD_LAST     = 3'd7;
    localparam logic [1:0]  BUS_NONE         = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  opcode = i2ch_pkg::OP_WR_DATA;
    logic [1:0]  bus_index = 2'd0;
    logic [7:0]  write_value = 8'd0;
    logic [31:0] event_mask = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  read_value;
    logic        bus_irq_fired;
    logic        mcu_irq_fired;

    int  mismatch_count;
    int  expected_left;
    int  live_items = 0;
    int  sent_items = 0;
    int  cycles = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  rx_long_hold = 1'b0;

    always #1 clk = ~clk;

    i2c_host_with_mcu_register_model #(.NUM_BUSES(NUM_BUSES)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .bus_index     (bus_index),
        .write_value   (write_value),
        .event_mask    (event_mask),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_value    (read_value),
        .bus_irq_fired (bus_irq_fired),
        .mcu_irq_fired (mcu_irq_fired)
    );

    i2ch_result_checker #(.NUM_BUSES(NUM_BUSES)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .bus_index      (bus_index),
        .write_value    (write_value),
        .event_mask     (event_mask),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_value     (read_value),
        .bus_irq_fired  (bus_irq_fired),
        .mcu_irq_fired  (mcu_irq_fired),
        .mismatch_count (mismatch_count),
        .expected_left  (expected_left)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // one access transfer; returns at the edge where it was accepted
    task automatic send(input logic [2:0] op, input logic [1:0] bus,
                        input logic [7:0] val, input logic [31:0] ev);
        int gap;
        gap = tx_idle_on ? $urandom_range(10, 0) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode      = op;
        bus_index   = bus;
        write_value = val;
        event_mask  = ev;
        in_valid    = 1'b1;
        do @(posedge clk); while (!in_ready);
        if (op == i2ch_pkg::OP_EVENT || (op <= i2ch_pkg::OP_RD_CTRL && bus < NUM_BUSES))
            live_items++;
        sent_items++;
        if (sent_items % 50 == 0)
            tx_idle_on = $urandom_range(2, 0) != 0;
    endtask

    task automatic pause_for_results();
        @(negedge clk);
        in_valid = 1'b0;
        wait (expected_left == 0);
    endtask

    function automatic logic [7:0] ctrl_byte(bit rd, bit start);
        logic [7:0] c;
        c = 8'($urandom);
        c[i2ch_pkg::CTRL_ENABLE] = 1'b1;
        c[i2ch_pkg::CTRL_READ]   = rd;
        c[i2ch_pkg::CTRL_START]  = start;
        return c;
    endfunction

    function automatic logic [7:0] pick_reg();
        case ($urandom_range(9, 0))
            0:       return i2ch_pkg::REG_PWR_FLAGS;
            1, 2:    return {i2ch_pkg::REG_IRQ_FLAGS, 2'($urandom)};
            3, 4:    return {i2ch_pkg::REG_IRQ_MASK, 2'($urandom)};
            5, 6:    return i2ch_pkg::REG_LCD_POWER;
            7:
            begin
                case ($urandom_range(4, 0))
                    0:       return i2ch_pkg::NOINC_A;
                    1:       return i2ch_pkg::NOINC_B;
                    2:       return i2ch_pkg::NOINC_C;
                    3:       return i2ch_pkg::NOINC_D;
                    default: return i2ch_pkg::NOINC_E;
                endcase
            end
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_bus();
        if ($urandom_range(7, 0) == 0)
            return 2'($urandom_range(NUM_BUSES - 1, 0));
        return i2ch_pkg::MCU_BUS;
    endfunction

    function automatic logic [7:0] pick_dev(logic [7:0] usual);
        if ($urandom_range(9, 0) == 0)
            return 8'($urandom);
        return usual;
    endfunction

    function automatic logic [31:0] pick_event();
        case ($urandom_range(4, 0))
            0:       return 32'd0;
            1, 2:    return 32'd1 << $urandom_range(31, 0);
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // device and register address phase; the start bit is sometimes left
    // off so the write count runs into saturation
    task automatic address_mcu(logic [1:0] bus, logic [7:0] dev, logic [7:0] regaddr);
        send(i2ch_pkg::OP_WR_DATA, bus, dev, $urandom);
        send(i2ch_pkg::OP_WR_CTRL, bus, ctrl_byte(1'b0, $urandom_range(7, 0) != 0),
             $urandom);
        send(i2ch_pkg::OP_WR_DATA, bus, regaddr, $urandom);
        send(i2ch_pkg::OP_WR_CTRL, bus, ctrl_byte(1'b0, 1'b0), $urandom);
    endtask

    initial
    begin
        int         kind;
        int         burst;
        bit         hold_done;
        bit         pause_done;
        logic [1:0] bus;

        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset values, extremes, disabled control, MCU write/read
        send(i2ch_pkg::OP_RD_CTRL, 2'd0, 8'h00, 32'd0);
        send(i2ch_pkg::OP_WR_DATA, 2'd0, 8'hFF, 32'hFFFF_FFFF);
        send(i2ch_pkg::OP_RD_DATA, 2'd0, 8'h00, 32'd0);
        send(i2ch_pkg::OP_WR_CTRL, 2'd2, 8'h7F, 32'd0);
        send(i2ch_pkg::OP_RD_CTRL, 2'd2, 8'h00, 32'd0);
        send(i2ch_pkg::OP_WR_DATA, i2ch_pkg::MCU_BUS, i2ch_pkg::MCU_DEV_WRITE, 32'd0);
        send(i2ch_pkg::OP_WR_CTRL, i2ch_pkg::MCU_BUS, 8'hC2, 32'd0);
        send(i2ch_pkg::OP_WR_DATA, i2ch_pkg::MCU_BUS, i2ch_pkg::REG_LCD_POWER, 32'd0);
        send(i2ch_pkg::OP_WR_CTRL, i2ch_pkg::MCU_BUS, 8'h80, 32'd0);
        send(i2ch_pkg::OP_WR_DATA, i2ch_pkg::MCU_BUS, 8'h3F, 32'd0);
        send(i2ch_pkg::OP_WR_CTRL, i2ch_pkg::MCU_BUS, 8'h80, 32'd0);
        send(i2ch_pkg::OP_RD_CTRL, i2ch_pkg::MCU_BUS, 8'h00, 32'd0);
        send(i2ch_pkg::OP_EVENT, 2'd0, 8'h00, 32'hFFFF_FFFF);
        send(i2ch_pkg::OP_EVENT, 2'd0, 8'h00, 32'd0);
        send(i2ch_pkg::OP_WR_DATA, BUS_NONE, 8'hFF, 32'd0);
        send(OP_RSVD_FIRST, 2'd0, 8'hFF, 32'hFFFF_FFFF);
        send(OP_RSVD_LAST, 2'd1, 8'h00, 32'd0);
        send(i2ch_pkg::OP_WR_DATA, i2ch_pkg::MCU_BUS, i2ch_pkg::MCU_DEV_READ, 32'd0);
        send(i2ch_pkg::OP_WR_CTRL, i2ch_pkg::MCU_BUS, 8'h82, 32'd0);
        send(i2ch_pkg::OP_WR_DATA, i2ch_pkg::MCU_BUS, {i2ch_pkg::REG_IRQ_FLAGS, 2'd3},
             32'd0);
        send(i2ch_pkg::OP_WR_CTRL, i2ch_pkg::MCU_BUS, 8'h80, 32'd0);
        send(i2ch_pkg::OP_WR_CTRL, i2ch_pkg::MCU_BUS, 8'hA0, 32'd0);
        send(i2ch_pkg::OP_RD_DATA, i2ch_pkg::MCU_BUS, 8'h00, 32'd0);
        send(i2ch_pkg::OP_WR_CTRL, i2ch_pkg::MCU_BUS, 8'hA0, 32'd0);
        send(i2ch_pkg::OP_RD_DATA, i2ch_pkg::MCU_BUS, 8'h00, 32'd0);

        while (live_items < ITEM_TARGET)
        begin
            if (!hold_done && live_items > 300)
            begin
                rx_long_hold = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && live_items > 700)
            begin
                pause_for_results();
                pause_done = 1'b1;
            end
            kind  = $urandom_range(99, 0);
            burst = $urandom_range(6, 1);
            bus   = pick_bus();
            if (kind < 35)
            begin
                address_mcu(bus, pick_dev(i2ch_pkg::MCU_DEV_WRITE), pick_reg());
                repeat (burst)
                begin
                    send(i2ch_pkg::OP_WR_DATA, bus, 8'($urandom), $urandom);
                    send(i2ch_pkg::OP_WR_CTRL, bus, ctrl_byte(1'b0, 1'b0), $urandom);
                end
            end
            else if (kind < 65)
            begin
                address_mcu(bus, pick_dev(i2ch_pkg::MCU_DEV_READ), pick_reg());
                repeat (burst)
                begin
                    send(i2ch_pkg::OP_WR_CTRL, bus, ctrl_byte(1'b1, 1'b0), $urandom);
                    if ($urandom_range(1, 0) != 0)
                        send(i2ch_pkg::OP_RD_DATA, bus, 8'($urandom), $urandom);
                    if ($urandom_range(5, 0) == 0)
                        send(i2ch_pkg::OP_RD_CTRL, bus, 8'($urandom), $urandom);
                end
            end
            else if (kind < 77)
            begin
                send(i2ch_pkg::OP_EVENT, 2'($urandom), 8'($urandom), pick_event());
            end
            else if (kind < 90)
            begin
                repeat ($urandom_range(3, 1))
                    send(3'($urandom), 2'($urandom), 8'($urandom), $urandom);
            end
            else
            begin
                send(3'($urandom_range(i2ch_pkg::OP_RD_CTRL, i2ch_pkg::OP_WR_DATA)),
                     2'($urandom_range(NUM_BUSES - 1, 0)), 8'($urandom), $urandom);
            end
            if ($urandom_range(60, 0) == 0)
                pause_for_results();
        end

        pause_for_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_left == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // result side: random stalls per transfer, one long hold-off on request
    initial
    begin
        int stall;
        int results;
        results = 0;
        wait (rst_n);
        forever
        begin
            if (results % 40 == 0)
                rx_idle_on = $urandom_range(2, 0) != 0;
            stall = rx_idle_on ? $urandom_range(10, 0) : 0;
            if (rx_long_hold)
            begin
                rx_long_hold = 1'b0;
                stall        = LONG_HOLD_CYCLES;
            end
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            results++;
        end
    end

endmodule
